// File: hdl/rsort_pkg.sv
package rsort_pkg;

  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int TAG_W   = 6;
  localparam int DATA_W  = 72;

  // One stored record. The time field sits in the lowest bits.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  elapsed;
  } record_t;

  // Control that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic sort;
    logic shift;
    logic parity;
    logic by_time;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  function automatic logic [TIME_W-1:0] key_of(record_t r, logic by_time);
    return by_time ? r.elapsed : r.count;
  endfunction

endpackage

// File: hdl/rsort_cell.sv
module rsort_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  rsort_pkg::cell_ctrl_t ctrl,
  input  logic                load_sel,
  input  rsort_pkg::record_t  load_rec,
  input  logic                used,
  input  logic                right_used,
  input  rsort_pkg::record_t  left_rec,
  input  rsort_pkg::record_t  right_rec,
  output rsort_pkg::record_t  rec
);
  import rsort_pkg::*;

  localparam logic ODD = 1'(IDX % 2);

  logic    take_right;
  logic    take_left;
  record_t rec_next;

  // In an odd-even transposition step this cell is either the lower or the
  // upper member of a compared pair. Only a strictly greater lower key swaps,
  // which keeps equal keys in arrival order.
  assign take_right = ctrl.sort && (ODD == ctrl.parity) && right_used &&
                      (key_of(rec, ctrl.by_time) > key_of(right_rec, ctrl.by_time));
  assign take_left  = ctrl.sort && (ODD != ctrl.parity) && used &&
                      (key_of(left_rec, ctrl.by_time) > key_of(rec, ctrl.by_time));

  always_comb begin
    rec_next = rec;
    if (load_sel) begin
      rec_next = load_rec;
    end else if (ctrl.shift || take_right) begin
      rec_next = right_rec;
    end else if (take_left) begin
      rec_next = left_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// File: hdl/record_insertion_sorter.sv
// Collects up to MAX_RECORDS records, one per cycle, into a row of cells in
// arrival order; records beyond that are dropped. The transfer marked tlast
// ends the set: the cells then run one odd-even transposition step per cycle,
// as many steps as there are stored records, on the key chosen by
// sort_by_time, and the stored records leave from the first cell in
// ascending key order, one per cycle while the output is ready, with tlast
// on the final one. Equal keys keep their arrival order. A set of n records
// thus takes n loads, n sort steps and n output transfers; no input
// is taken between the final record and the end of its output burst.
module record_insertion_sorter #(
  parameter int MAX_RECORDS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,          // sort_by_time
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // elapsed_time[31:0], iteration_count[63:32], record_tag[69:64], zero pad
  input  logic [rsort_pkg::DATA_W-1:0] s_axis_tdata,
  input  logic                        s_axis_tlast,      // final_record
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_time[31:0], out_count[63:32], out_tag[69:64], zero pad
  output logic [rsort_pkg::DATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast       // out_last
);
  import rsort_pkg::*;

  localparam int FW = $clog2(MAX_RECORDS + 1);
  localparam int RECORD_W = TAG_W + COUNT_W + TIME_W;

  state_t        state;
  logic [FW-1:0] fill;
  logic [FW-1:0] pass;
  logic          sort_by_time;

  logic          in_xfer;
  logic          out_xfer;
  logic          load;
  cell_ctrl_t    ctrl;
  record_t       load_rec;
  record_t       recs [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] used;
  logic [MAX_RECORDS-1:0] load_sel;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_LOAD);
  assign m_axis_tvalid = (state == ST_SEND);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign load          = in_xfer && (fill < FW'(MAX_RECORDS));
  assign load_rec      = record_t'(s_axis_tdata[RECORD_W-1:0]);

  assign ctrl.sort    = (state == ST_SORT);
  assign ctrl.shift   = out_xfer;
  assign ctrl.parity  = pass[0];
  assign ctrl.by_time = sort_by_time;

  assign m_axis_tdata = {{(DATA_W - RECORD_W){1'b0}}, recs[0]};
  assign m_axis_tlast = (fill == FW'(1));

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    assign used[i]     = (FW'(i) < fill);
    assign load_sel[i] = load && (fill == FW'(i));

    rsort_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_sel   (load_sel[i]),
      .load_rec   (load_rec),
      .used       (used[i]),
      .right_used ((i == MAX_RECORDS - 1) ? 1'b0 : used[(i + 1) % MAX_RECORDS]),
      .left_rec   ((i == 0) ? recs[0] : recs[(i + MAX_RECORDS - 1) % MAX_RECORDS]),
      .right_rec  ((i == MAX_RECORDS - 1) ? recs[i] : recs[(i + 1) % MAX_RECORDS]),
      .rec        (recs[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      fill         <= '0;
      pass         <= '0;
      sort_by_time <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sort_by_time <= cfg_data;
      end
      case (state)
        ST_LOAD: begin
          if (load) begin
            fill <= fill + FW'(1);
          end
          if (in_xfer && s_axis_tlast) begin
            state <= ST_SORT;
            pass  <= '0;
          end
        end
        ST_SORT: begin
          pass <= pass + FW'(1);
          if (pass == fill - FW'(1)) begin
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (out_xfer) begin
            fill <= fill - FW'(1);
            if (fill == FW'(1)) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Input and output are never open in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output open together");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_RECORDS))
    else $error("fill count beyond capacity");

  a_send_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT || state == ST_SEND) |-> fill != '0)
    else $error("sorting or sending an empty set");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_axis_tlast) |=> (s_axis_tready && fill == '0))
    else $error("store not emptied after the final transfer");

endmodule
